### sv/pwm_pad_safe_handover_macros.svh
// assertion macros used by the pad handover core
`ifndef PWM_PAD_SAFE_HANDOVER_MACROS_SVH
`define PWM_PAD_SAFE_HANDOVER_MACROS_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define PPHS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// antecedent in a cycle implies consequent in the next
`define PPHS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PPHS_ASSERT(name, prop, msg)
`define PPHS_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

### sv/pphs_pkg.sv
// types, codes and constants of the pad handover block
package pphs_pkg;

  // width of the elapsed and pulse width counters
  localparam int unsigned TIMER_BITS = 17;
  // width of the timeout limit registers
  localparam int unsigned LIMIT_BITS = 17;
  // width used for comparing counters against limits and bounds
  localparam int unsigned CMP_W = (TIMER_BITS > LIMIT_BITS) ? TIMER_BITS : LIMIT_BITS;
  // saturation value of the counters
  localparam logic [TIMER_BITS-1:0] TMAX = '1;
  // number of phase evaluations chained inside one tick
  localparam int unsigned STEPS = 3;

  // reset values of the configuration registers
  localparam logic [14:0] EXPECTED_RST = 15'd1500;
  localparam logic [9:0]  TOLERANCE_RST = 10'd120;
  localparam logic [LIMIT_BITS-1:0] VERIFY_RST = LIMIT_BITS'(60000);
  localparam logic [LIMIT_BITS-1:0] GAP_RST = LIMIT_BITS'(42000);

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_V_WAIT_LOW  = 3'd1,
    PH_V_WAIT_HIGH = 3'd2,
    PH_V_MEASURE   = 3'd3,
    PH_G_WAIT_HIGH = 3'd4,
    PH_G_WAIT_LOW  = 3'd5,
    PH_R_WAIT_LOW  = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    FAIL_OK          = 2'd0,
    FAIL_NO_SOURCE   = 2'd1,
    FAIL_WRONG_PULSE = 2'd2,
    FAIL_NO_GAP      = 2'd3
  } fail_e;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_CONNECT = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_EXPECTED  = 2'd0,
    CFG_TOLERANCE = 2'd1,
    CFG_VERIFY    = 2'd2,
    CFG_GAP       = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [14:0]           expected_pulse_us;
    logic [9:0]            pulse_tolerance_us;
    logic [LIMIT_BITS-1:0] verify_timeout_us;
    logic [LIMIT_BITS-1:0] gap_limit_us;
  } cfg_t;

  typedef struct packed {
    logic [1:0] command;
    logic       verify_now;
    logic       fresh_gap;
    logic [2:0] channel;
    logic       ref_level;
    logic       pad_level;
  } item_t;

  // packed so that pad_routed lands in bit 0 of the output beat
  typedef struct packed {
    logic [1:0] fail_code;
    logic       done_res;
    logic       busy_res;
    logic [2:0] pad_channel;
    logic       pad_routed;
  } result_t;

  // handshake between the input stage and the core
  typedef struct packed {
    logic valid;
  } stage_ctl_t;

endpackage

### sv/pphs_cfg_regs.sv
// configuration register file of the pad handover block
module pphs_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [16:0]       cfg_data_i,
  output pphs_pkg::cfg_t    cfg_o
);

  pphs_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (pphs_pkg::cfg_idx_e'(cfg_index_i))
        pphs_pkg::CFG_EXPECTED:  cfg_d.expected_pulse_us = cfg_data_i[14:0];
        pphs_pkg::CFG_TOLERANCE: cfg_d.pulse_tolerance_us = cfg_data_i[9:0];
        pphs_pkg::CFG_VERIFY:
          cfg_d.verify_timeout_us = cfg_data_i[pphs_pkg::LIMIT_BITS-1:0];
        pphs_pkg::CFG_GAP:
          cfg_d.gap_limit_us = cfg_data_i[pphs_pkg::LIMIT_BITS-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_pulse_us  <= pphs_pkg::EXPECTED_RST;
      cfg_q.pulse_tolerance_us <= pphs_pkg::TOLERANCE_RST;
      cfg_q.verify_timeout_us  <= pphs_pkg::VERIFY_RST;
      cfg_q.gap_limit_us       <= pphs_pkg::GAP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/pphs_in_stage.sv
// input register that holds one tick beat until the core takes it
module pphs_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,
  input  logic [1:0]          s_axis_tuser,
  input  logic                pop_i,
  output pphs_pkg::stage_ctl_t ctl_o,
  output pphs_pkg::item_t     item_o
);

  logic            valid_q, valid_d;
  pphs_pkg::item_t item_q, item_d;
  logic            take;

  // a beat is taken when the register is empty or drains this cycle
  assign s_axis_tready = !valid_q || pop_i;
  assign take = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  // unpack the beat fields
  always_comb begin
    item_d            = item_q;
    if (take) begin
      item_d.command    = s_axis_tuser;
      item_d.verify_now = s_axis_tdata[0];
      item_d.fresh_gap  = s_axis_tdata[1];
      item_d.channel    = s_axis_tdata[4:2];
      item_d.ref_level  = s_axis_tdata[5];
      item_d.pad_level  = s_axis_tdata[6];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign ctl_o.valid = valid_q;
  assign item_o      = item_q;

endmodule

### sv/pphs_core.sv
// handover sequencer: phase state, counters, routing and result register
`include "pwm_pad_safe_handover_macros.svh"

module pphs_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pphs_pkg::cfg_t       cfg_i,
  input  pphs_pkg::stage_ctl_t ctl_i,
  input  pphs_pkg::item_t      item_i,
  output logic                 pop_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output pphs_pkg::result_t    res_o
);

  localparam int unsigned TB = pphs_pkg::TIMER_BITS;
  localparam int unsigned CW = pphs_pkg::CMP_W;

  pphs_pkg::phase_e  phase_q, phase_d;
  logic [TB-1:0]     elapsed_q, elapsed_d;
  logic [TB-1:0]     width_q, width_d;
  logic              fresh_q, fresh_d;
  logic [2:0]        pend_q, pend_d;
  logic              routed_q, routed_d;
  logic [2:0]        rchan_q, rchan_d;
  pphs_pkg::fail_e   fail_q, fail_d;
  logic              done_d;
  logic              out_valid_q;
  pphs_pkg::result_t res_q, res_d;
  logic [14:0]       lo_bound;
  logic [15:0]       hi_bound;

  // the core advances when an item waits and the result slot is free or drains this cycle
  assign pop_o = ctl_i.valid && (!out_valid_q || m_axis_tready);

  // pulse width window, lower bound clamped at zero
  always_comb begin
    lo_bound = (cfg_i.expected_pulse_us > 15'(cfg_i.pulse_tolerance_us))
             ? cfg_i.expected_pulse_us - 15'(cfg_i.pulse_tolerance_us) : 15'd0;
    hi_bound = 16'(cfg_i.expected_pulse_us) + 16'(cfg_i.pulse_tolerance_us);
  end

  // one tick: command start or counter advance, then up to three chained phase evaluations
  always_comb begin
    logic more;
    logic fin;
    logic to_v;
    logic to_g;
    pphs_pkg::fail_e f;

    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    width_d   = width_q;
    fresh_d   = fresh_q;
    pend_d    = pend_q;
    routed_d  = routed_q;
    rchan_d   = rchan_q;
    fail_d    = fail_q;
    done_d    = 1'b0;
    more      = 1'b1;
    fin       = 1'b0;
    to_v      = 1'b0;
    to_g      = 1'b0;
    f         = pphs_pkg::FAIL_OK;

    // command decode or counter advance
    if (phase_q != pphs_pkg::PH_IDLE) begin
      elapsed_d = (elapsed_q == pphs_pkg::TMAX) ? elapsed_q : elapsed_q + 1'b1;
    end else if (item_i.command == pphs_pkg::CMD_CONNECT) begin
      fail_d    = pphs_pkg::FAIL_OK;
      pend_d    = item_i.channel;
      fresh_d   = item_i.fresh_gap;
      elapsed_d = '0;
      width_d   = '0;
      if (item_i.verify_now) begin
        phase_d = pphs_pkg::PH_V_WAIT_LOW;
      end else begin
        phase_d = item_i.fresh_gap ? pphs_pkg::PH_G_WAIT_HIGH : pphs_pkg::PH_G_WAIT_LOW;
      end
    end else if (item_i.command == pphs_pkg::CMD_RELEASE) begin
      fail_d    = pphs_pkg::FAIL_OK;
      elapsed_d = '0;
      phase_d   = pphs_pkg::PH_R_WAIT_LOW;
    end

    // stages that complete on the same sample
    for (int i = 0; i < pphs_pkg::STEPS; i++) begin
      if (more) begin
        more = 1'b0;
        fin  = 1'b0;
        f    = pphs_pkg::FAIL_OK;
        to_v = (CW'(elapsed_d) > CW'(cfg_i.verify_timeout_us))
            || (elapsed_d == pphs_pkg::TMAX);
        to_g = (CW'(elapsed_d) > CW'(cfg_i.gap_limit_us))
            || (elapsed_d == pphs_pkg::TMAX);
        case (phase_d)
          pphs_pkg::PH_V_WAIT_LOW: begin
            if (item_i.ref_level) begin
              if (to_v) begin
                f   = pphs_pkg::FAIL_NO_SOURCE;
                fin = 1'b1;
              end
            end else begin
              phase_d = pphs_pkg::PH_V_WAIT_HIGH;
              more    = 1'b1;
            end
          end
          pphs_pkg::PH_V_WAIT_HIGH: begin
            if (!item_i.ref_level) begin
              if (to_v) begin
                f   = pphs_pkg::FAIL_NO_SOURCE;
                fin = 1'b1;
              end
            end else begin
              width_d = '0;
              phase_d = pphs_pkg::PH_V_MEASURE;
              more    = 1'b1;
            end
          end
          pphs_pkg::PH_V_MEASURE: begin
            if (item_i.ref_level) begin
              width_d = (width_d == pphs_pkg::TMAX) ? width_d : width_d + 1'b1;
              if (to_v) begin
                f   = pphs_pkg::FAIL_NO_SOURCE;
                fin = 1'b1;
              end
            end else if ((CW'(width_d) < CW'(lo_bound)) || (CW'(width_d) > CW'(hi_bound)))
            begin
              f   = pphs_pkg::FAIL_WRONG_PULSE;
              fin = 1'b1;
            end else begin
              elapsed_d = '0;
              phase_d   = fresh_d ? pphs_pkg::PH_G_WAIT_HIGH : pphs_pkg::PH_G_WAIT_LOW;
              more      = 1'b1;
            end
          end
          pphs_pkg::PH_G_WAIT_HIGH: begin
            if (!item_i.ref_level) begin
              if (to_g) begin
                f   = pphs_pkg::FAIL_NO_GAP;
                fin = 1'b1;
              end
            end else begin
              phase_d = pphs_pkg::PH_G_WAIT_LOW;
              more    = 1'b1;
            end
          end
          pphs_pkg::PH_G_WAIT_LOW: begin
            if (item_i.ref_level) begin
              if (to_g) begin
                f   = pphs_pkg::FAIL_NO_GAP;
                fin = 1'b1;
              end
            end else begin
              routed_d = 1'b1;
              rchan_d  = pend_d;
              fin      = 1'b1;
            end
          end
          pphs_pkg::PH_R_WAIT_LOW: begin
            if (item_i.pad_level) begin
              if (to_g) begin
                f   = pphs_pkg::FAIL_NO_GAP;
                fin = 1'b1;
              end
            end else begin
              routed_d = 1'b0;
              rchan_d  = 3'd0;
              fin      = 1'b1;
            end
          end
          default: phase_d = pphs_pkg::PH_IDLE;
        endcase
        if (fin) begin
          fail_d  = f;
          phase_d = pphs_pkg::PH_IDLE;
          done_d  = 1'b1;
        end
      end
    end
  end

  // result of the tick, state after the tick
  always_comb begin
    res_d.pad_routed  = routed_d;
    res_d.pad_channel = routed_d ? rchan_d : 3'd0;
    res_d.busy_res    = (phase_d != pphs_pkg::PH_IDLE);
    res_d.done_res    = done_d;
    res_d.fail_code   = fail_d;
  end

  // state registers, updated once per consumed tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= pphs_pkg::PH_IDLE;
      elapsed_q <= '0;
      width_q   <= '0;
      fresh_q   <= 1'b0;
      pend_q    <= 3'd0;
      routed_q  <= 1'b0;
      rchan_q   <= 3'd0;
      fail_q    <= pphs_pkg::FAIL_OK;
    end else if (pop_o) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      width_q   <= width_d;
      fresh_q   <= fresh_d;
      pend_q    <= pend_d;
      routed_q  <= routed_d;
      rchan_q   <= rchan_d;
      fail_q    <= fail_d;
    end
  end

  // result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign res_o         = res_q;

  // checks
  `PPHS_ASSERT(a_done_not_busy, !(out_valid_q && res_q.done_res && res_q.busy_res), "done result still busy")
  `PPHS_ASSERT(a_unrouted_chan_zero, routed_q || (rchan_q == 3'd0), "channel kept while unrouted")
  `PPHS_ASSERT_NEXT(a_idle_tick_stays, pop_o && (phase_q == pphs_pkg::PH_IDLE) && (item_i.command != pphs_pkg::CMD_CONNECT) && (item_i.command != pphs_pkg::CMD_RELEASE), phase_q == pphs_pkg::PH_IDLE, "idle left without command")
  `PPHS_ASSERT_NEXT(a_state_holds, !pop_o, $stable(phase_q) && $stable(elapsed_q) && $stable(routed_q), "state moved without a tick")

endmodule

### sv/pwm_pad_safe_handover.sv
// a tick beat is held in the input register, its result beat in the result register
// throughput: one tick beat per cycle while results are taken; up to three phase evaluations chain in one pass
// a stalled result register holds the input register; ready passes back in the same cycle
// reset: rst_ni low clears phase, counters, routing and fail code, loads default limits
// top level of the pwm pad handover sequencer
module pwm_pad_safe_handover (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // verify_now, fresh_gap, channel[2:0], ref_level, pad_level, zero pad bit
  input  logic [7:0]  s_axis_tdata,
  // command[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pad_routed, pad_channel[2:0], busy_res, done_res, fail_code[1:0]
  output logic [7:0]  m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);

  pphs_pkg::cfg_t       cfg;
  pphs_pkg::stage_ctl_t ctl;
  pphs_pkg::item_t      item;
  pphs_pkg::result_t    res;
  logic                 pop;

  // configuration registers
  pphs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // input register
  pphs_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .pop_i         (pop),
    .ctl_o         (ctl),
    .item_o        (item)
  );

  // sequencer and result register
  pphs_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .ctl_i         (ctl),
    .item_i        (item),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .res_o         (res)
  );

  assign m_axis_tdata = res;

endmodule
